// File: sv/mfq_pkg.sv
// Package with the shared types, constants and ring index helper of the message queue.
package mfq_pkg;

  // Ring geometry.
  localparam int Depth = 16;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int CntXW = CntW + 1;

  // Fixed field widths.
  localparam int OpW   = 2;
  localparam int IdW   = 16;
  localparam int ParW  = 32;
  localparam int StatW = 2;
  localparam int CapW  = 5;
  localparam int FillW = 5;
  localparam int CmpW  = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [OpW-1:0] {
    OP_POST   = 2'd0,
    OP_UNIQUE = 2'd1,
    OP_ACCEPT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_DUP   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } state_e;

  // One stored message.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [ParW-1:0] lo;
    logic [ParW-1:0] hi;
  } entry_t;

  // Advance a ring index, wrapping at the capacity in effect or at the ring end.
  function automatic idx_t next_slot(idx_t idx, cnt_t cap);
    logic [CntXW-1:0] n;
    n = CntXW'(idx) + CntXW'(1);
    if (n >= CntXW'(cap) || n >= CntXW'(Depth)) begin
      return '0;
    end
    return IdxW'(n);
  endfunction

endpackage

// File: sv/message_fifo_with_unique_post.sv
// Circular message queue with plain post, unique post and accept of the oldest entry.
//
//  Channel   | Handshake                | Payload
//  ----------+--------------------------+------------------------------------------------
//  command   | start_i, busy_o          | opcode_i, message_id_i, low_param_i, high_param_i
//  result    | done_o (one-cycle strobe) | status_o, out_message_id_o, out_low_param_o,
//            |                          | out_high_param_o, fill_count_o
//  config    | queue_capacity_we_i      | queue_capacity_i
//
// A post, or the unused opcode, gives its result in the cycle after it is taken and
// busy_o stays low. An accept of a non-empty queue does one memory read and then the
// pop. A unique post reads one stored id per cycle from the single memory read port,
// one id for each held entry, until an id matches or every held entry has been read.
// Reset clears the indices and the count and sets the capacity to 16; the memory
// itself is not cleared. The receiver cannot stall: each result shows for one cycle.
module message_fifo_with_unique_post (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [mfq_pkg::OpW-1:0]        opcode_i,
  input  logic [mfq_pkg::IdW-1:0]        message_id_i,
  input  logic [mfq_pkg::ParW-1:0]       low_param_i,
  input  logic [mfq_pkg::ParW-1:0]       high_param_i,
  input  logic                           queue_capacity_we_i,
  input  logic [mfq_pkg::CapW-1:0]       queue_capacity_i,
  output logic                           done_o,
  output logic [mfq_pkg::StatW-1:0]      status_o,
  output logic [mfq_pkg::IdW-1:0]        out_message_id_o,
  output logic [mfq_pkg::ParW-1:0]       out_low_param_o,
  output logic [mfq_pkg::ParW-1:0]       out_high_param_o,
  output logic [mfq_pkg::FillW-1:0]      fill_count_o
);
  import mfq_pkg::*;

  // Control state.
  state_e            state_q, state_d;
  idx_t              wr_idx_q, wr_idx_d;
  idx_t              rd_idx_q, rd_idx_d;
  idx_t              scan_idx_q, scan_idx_d;
  cnt_t              count_q, count_d;
  cnt_t              left_q, left_d;
  logic [CapW-1:0]   cap_q, cap_d;
  logic              done_q, done_d;

  // Pending unique post and result payload.
  entry_t            pend_q, pend_d;
  logic [StatW-1:0]  status_q, status_d;
  entry_t            res_q, res_d;
  logic [FillW-1:0]  fill_q, fill_d;

  // Memory and its ports.
  entry_t            mem [Depth];
  entry_t            rdata_q;
  logic              mem_we, mem_re;
  idx_t              mem_waddr, mem_raddr;
  entry_t            mem_wdata;

  logic              accept;
  logic              full;
  logic              id_hit;
  logic              post_req;
  cnt_t              eff_cap;
  entry_t            in_entry;
  idx_t              scan_next;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign in_entry = '{id: message_id_i, lo: low_param_i, hi: high_param_i};

  // Capacity in effect saturates at the ring depth.
  assign eff_cap = (CmpW'(cap_q) > CmpW'(Depth)) ? CntW'(Depth) : CntW'(cap_q);
  assign full    = (count_q >= eff_cap);
  assign id_hit  = (rdata_q.id == pend_q.id);
  assign scan_next = next_slot(scan_idx_q, eff_cap);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && count_q != '0) begin
          if (op_e'(opcode_i) == OP_UNIQUE) begin
            state_d = ST_SCAN;
          end else if (op_e'(opcode_i) == OP_ACCEPT) begin
            state_d = ST_POP;
          end
        end
      end
      ST_SCAN: begin
        if (id_hit || left_q == CntW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result.
  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    scan_idx_d = scan_idx_q;
    count_d    = count_q;
    left_d     = left_q;
    cap_d      = cap_q;
    pend_d     = pend_q;
    done_d     = 1'b0;
    status_d   = status_q;
    res_d      = res_q;
    fill_d     = fill_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_q;
    mem_waddr  = wr_idx_q;
    mem_wdata  = (state_q == ST_IDLE) ? in_entry : pend_q;
    post_req   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(opcode_i))
            OP_POST: begin
              post_req = 1'b1;
            end
            OP_UNIQUE: begin
              if (count_q == '0) begin
                post_req = 1'b1;
              end else begin
                mem_re     = 1'b1;
                scan_idx_d = rd_idx_q;
                left_d     = count_q;
                pend_d     = in_entry;
              end
            end
            OP_ACCEPT: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STAT_EMPTY;
                res_d    = '0;
                fill_d   = FillW'(count_q);
              end else begin
                mem_re = 1'b1;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = STAT_OK;
              res_d    = '0;
              fill_d   = FillW'(count_q);
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (id_hit) begin
          done_d   = 1'b1;
          status_d = STAT_DUP;
          res_d    = '0;
          fill_d   = FillW'(count_q);
        end else if (left_q == CntW'(1)) begin
          post_req = 1'b1;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = scan_next;
          scan_idx_d = scan_next;
          left_d     = left_q - CntW'(1);
        end
      end
      ST_POP: begin
        done_d   = 1'b1;
        status_d = STAT_OK;
        res_d    = rdata_q;
        rd_idx_d = next_slot(rd_idx_q, eff_cap);
        count_d  = count_q - CntW'(1);
        fill_d   = FillW'(count_q - CntW'(1));
      end
      default: begin
      end
    endcase

    // Append at the write index unless the queue is full.
    if (post_req) begin
      done_d = 1'b1;
      res_d  = '0;
      if (full) begin
        status_d = STAT_FULL;
        fill_d   = FillW'(count_q);
      end else begin
        status_d = STAT_OK;
        mem_we   = 1'b1;
        wr_idx_d = next_slot(wr_idx_q, eff_cap);
        count_d  = count_q + CntW'(1);
        fill_d   = FillW'(count_q + CntW'(1));
      end
    end

    // A capacity write empties the queue.
    if (queue_capacity_we_i) begin
      cap_d    = queue_capacity_i;
      wr_idx_d = '0;
      rd_idx_d = '0;
      count_d  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      scan_idx_q <= '0;
      count_q    <= '0;
      left_q     <= '0;
      cap_q      <= CapReset;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      scan_idx_q <= scan_idx_d;
      count_q    <= count_d;
      left_q     <= left_d;
      cap_q      <= cap_d;
      done_q     <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    status_q <= status_d;
    res_q    <= res_d;
    fill_q   <= fill_d;
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_message_id_o = res_q.id;
  assign out_low_param_o  = res_q.lo;
  assign out_high_param_o = res_q.hi;
  assign fill_count_o     = fill_q;

endmodule

// File: sv/mfq_checker.sv
// Port-level checker for the message queue and its bind to the top level.
module mfq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [mfq_pkg::OpW-1:0]        opcode_i,
  input logic                           done_o,
  input logic [mfq_pkg::StatW-1:0]      status_o,
  input logic [mfq_pkg::IdW-1:0]        out_message_id_o,
  input logic [mfq_pkg::ParW-1:0]       out_low_param_o,
  input logic [mfq_pkg::ParW-1:0]       out_high_param_o,
  input logic [mfq_pkg::FillW-1:0]      fill_count_o
);
  import mfq_pkg::*;

  // Only a successful accept carries entry fields.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STAT_OK |->
      out_message_id_o == '0 && out_low_param_o == '0 && out_high_param_o == '0)
    else $error("entry fields not zero on a failed operation");

  // An empty report leaves nothing in the queue.
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STAT_EMPTY |-> fill_count_o == '0)
    else $error("empty status with a non-zero fill count");

  // A plain post or the unused opcode completes in the next cycle.
  a_post_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == OP_POST || opcode_i == OP_NONE)
      |=> done_o && !busy_o)
    else $error("post did not complete in one cycle");

  // The fill count never exceeds the ring depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> int'(fill_count_o) <= Depth)
    else $error("fill count above ring depth");

endmodule

bind message_fifo_with_unique_post mfq_checker u_mfq_checker (.*);
